@@ design/mbps_pkg.sv @@
package mbps_pkg;

	localparam int PAT_BYTES = 24;
	localparam int SPAN_W    = 5;
	localparam int OFFSET_W  = 25;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 64;

	localparam logic [CFG_W-1:0]  CARE_LOW_RST = 64'h0000_0000_FFFF_FFFF;
	localparam logic [SPAN_W-1:0] SPAN_RST     = 5'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VALUE_LOW  = 4'd0,
		REG_VALUE_MID  = 4'd1,
		REG_VALUE_HIGH = 4'd2,
		REG_MASK_LOW   = 4'd3,
		REG_MASK_MID   = 4'd4,
		REG_MASK_HIGH  = 4'd5,
		REG_SPAN       = 4'd6,
		REG_BIAS       = 4'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} out_t;

	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] value;
		logic [PAT_BYTES-1:0][7:0] mask;
		logic [SPAN_W-1:0]         span_raw;
		logic [SPAN_W-1:0]         bias;
	} cfg_t;

	// True when every bit selected by the mask agrees with the pattern.
	function automatic logic byte_hit(input logic [7:0] b, input logic [7:0] p,
			input logic [7:0] m);
		return ((b ^ p) & m) == 8'd0;
	endfunction

endpackage

@@ design/masked_byte_pattern_scanner.sv @@
// Masked byte pattern scanner. Takes one byte per clock and, for each buffer, reports on the
// transaction carrying the last byte whether the configured pattern was found and at which
// start position plus bias. Earlier bytes sit in a row of WINDOW-1 cells; at every byte each
// cell inside the span compares its stored byte with the pattern byte for its distance, so
// the whole span is decided in the byte's arrival cycle and registered at its end. A byte is
// taken whenever the result register is empty or being emptied, so while results are taken
// the rate is one byte per clock; configuration writes are taken in any cycle.
module masked_byte_pattern_scanner
	import mbps_pkg::*;
#(
	parameter int MAX_BYTES = 16777216,
	parameter int WINDOW    = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int POS_W = $clog2(MAX_BYTES + 1);
	localparam int NCELL = WINDOW - 1;
	localparam int SUM_W = (POS_W + 1 > OFFSET_W) ? POS_W + 1 : OFFSET_W;
	localparam logic [SPAN_W-1:0] WIN_SPAN = SPAN_W'(WINDOW);

	cfg_t cfg;

	logic [POS_W-1:0] pos_q;
	logic             seen_q;
	logic [POS_W-1:0] start_q;
	logic             out_valid_q;
	out_t             out_q;

	logic [SPAN_W-1:0] span_eff;
	logic [SPAN_W-1:0] span_m1;
	logic              accept;
	logic              in_range;
	logic              cur_hit;
	logic              new_match;
	logic [POS_W-1:0]  start_new;
	logic [POS_W-1:0]  start_sel;
	logic [SUM_W-1:0]  offset_sum;
	logic              found_sel;

	logic [NCELL-1:0][7:0]        cell_byte;
	logic [NCELL-1:0]             cell_hit;
	logic [NCELL-1:0]             cell_cmp;
	logic [NCELL-1:0][SPAN_W-1:0] cell_idx;

	mbps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	always_comb begin
		if (cfg.span_raw == '0) begin
			span_eff = SPAN_W'(1);
		end else if (cfg.span_raw > WIN_SPAN) begin
			span_eff = WIN_SPAN;
		end else begin
			span_eff = cfg.span_raw;
		end
	end

	assign span_m1 = span_eff - SPAN_W'(1);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		localparam logic [SPAN_W-1:0] DIST = SPAN_W'(i + 1);
		logic [7:0] byte_in;

		if (i == 0) begin : g_head
			assign byte_in = in_data.data_byte;
		end else begin : g_body
			assign byte_in = cell_byte[i-1];
		end

		assign cell_cmp[i] = DIST < span_eff;
		assign cell_idx[i] = cell_cmp[i] ? span_m1 - DIST : '0;

		mbps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (accept && in_range),
			.byte_in   (byte_in),
			.pat_byte  (cfg.value[cell_idx[i]]),
			.mask_byte (cfg.mask[cell_idx[i]]),
			.cmp_en    (cell_cmp[i]),
			.byte_out  (cell_byte[i]),
			.hit       (cell_hit[i])
		);
	end

	assign cur_hit   = byte_hit(in_data.data_byte, cfg.value[span_m1], cfg.mask[span_m1]);
	assign in_range  = pos_q < POS_W'(MAX_BYTES);
	assign new_match = in_range && !seen_q && (pos_q >= POS_W'(span_m1)) && cur_hit
			&& (&cell_hit);
	assign start_new = pos_q - POS_W'(span_m1);

	assign found_sel  = seen_q || new_match;
	assign start_sel  = seen_q ? start_q : start_new;
	assign offset_sum = SUM_W'(start_sel) + SUM_W'(cfg.bias);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			seen_q      <= 1'b0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && in_data.last_byte) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (in_data.last_byte) begin
					pos_q   <= '0;
					seen_q  <= 1'b0;
					start_q <= '0;
				end else begin
					if (in_range) begin
						pos_q <= POS_W'(pos_q + 1'b1);
					end
					if (new_match) begin
						seen_q  <= 1'b1;
						start_q <= start_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.last_byte) begin
			out_q.found  <= found_sel;
			out_q.offset <= found_sel ? offset_sum[OFFSET_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ design/mbps_cfg.sv @@
module mbps_cfg
	import mbps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	logic [2:0][CFG_W-1:0] value_q;
	logic [2:0][CFG_W-1:0] mask_q;
	logic [SPAN_W-1:0]     span_q;
	logic [SPAN_W-1:0]     bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			mask_q  <= {{CFG_W{1'b0}}, {CFG_W{1'b0}}, CARE_LOW_RST};
			span_q  <= SPAN_RST;
			bias_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_VALUE_LOW:  value_q[0] <= wr_data;
				REG_VALUE_MID:  value_q[1] <= wr_data;
				REG_VALUE_HIGH: value_q[2] <= wr_data;
				REG_MASK_LOW:   mask_q[0]  <= wr_data;
				REG_MASK_MID:   mask_q[1]  <= wr_data;
				REG_MASK_HIGH:  mask_q[2]  <= wr_data;
				REG_SPAN:       span_q     <= wr_data[SPAN_W-1:0];
				REG_BIAS:       bias_q     <= wr_data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.value    = value_q;
	assign cfg.mask     = mask_q;
	assign cfg.span_raw = span_q;
	assign cfg.bias     = bias_q;

endmodule

@@ design/mbps_cell.sv @@
module mbps_cell
	import mbps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic [7:0] byte_in,
	input  logic [7:0] pat_byte,
	input  logic [7:0] mask_byte,
	input  logic       cmp_en,
	output logic [7:0] byte_out,
	output logic       hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	// A cell outside the current span never blocks a match.
	assign hit      = !cmp_en || byte_hit(byte_q, pat_byte, mask_byte);
	assign byte_out = byte_q;

endmodule

@@ design/mbps_checker.sv @@
module mbps_checker
	import mbps_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input in_t                  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input out_t                 out_data
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// An empty result register never holds back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

	// Every accepted last byte yields a result in the next cycle.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_byte |=> out_valid)
		else $error("last byte gave no result");

	// A fresh result follows only a last-byte transaction.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_byte))
		else $error("result without a last byte");

	a_miss_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.offset == '0)
		else $error("nonzero offset on a miss");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
